// ===== rtl/gs_pkg.sv =====
package gs_pkg;

   localparam int MAX_ORDER_DEF = 8;
   localparam int Q_FRAC = 24;
   localparam int DIV_W = 32 + Q_FRAC;

   localparam logic [3:0] RESET_ORDER = 4'd8;
   localparam logic [30:0] RESET_TOLERANCE = 31'd17;
   localparam logic [15:0] RESET_LIMIT = 16'd1000;

   localparam logic [1:0] CSR_ORDER = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE = 2'd1;
   localparam logic [1:0] CSR_LIMIT = 2'd2;

   localparam logic [1:0] FUNC_MATRIX = 2'd0;
   localparam logic [1:0] FUNC_RHS = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? Q_MIN : Q_MAX;
      end
      return s[31:0];
   endfunction

   function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      if (s[32] != s[31]) begin
         return s[32] ? Q_MIN : Q_MAX;
      end
      return s[31:0];
   endfunction

   // floor shift of the product, saturated to the q8.24 range
   function automatic logic signed [31:0] prod_to_q(input logic signed [63:0] p);
      logic all_same;
      all_same = (p[63:55] == {9{p[55]}});
      if (!all_same) begin
         return p[63] ? Q_MIN : Q_MAX;
      end
      return p[55:24];
   endfunction

endpackage

// ===== rtl/gauss_seidel_linear_solver_top.sv =====
// Gauss-Seidel solver for A x = b in signed q8.24. Load transactions (func 0 matrix entry,
// func 1 right-hand side entry) are accepted while idle. A start transaction clears x, then
// repeats a sweep over the rows followed by a full residual pass until the largest
// |b - A x| is below tolerance or iteration_limit sweeps are done; a zero diagonal ends
// the solve at once with zeros. One multiplier and one radix-2 restoring divider are
// shared under a sequencer: each matrix term passes through the read, multiply and
// accumulate states, each sweep row then waits on the divider, and the n results leave one
// per cycle while the output is not stalled. The input is not ready while a solve runs.
module gauss_seidel_linear_solver_top #(
   parameter int MAX_ORDER = gs_pkg::MAX_ORDER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // row, col, entry_value
   input  logic [1:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // unknown_index, solution_value
   output logic        rsp_tuser,   // converged
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IW = $clog2(MAX_ORDER);
   localparam int NW = $clog2(MAX_ORDER + 1);
   localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_READ = 8'b0000_0010,
      S_MUL  = 8'b0000_0100,
      S_ACC  = 8'b0000_1000,
      S_DIV  = 8'b0001_0000,
      S_RES  = 8'b0010_0000,
      S_CHK  = 8'b0100_0000,
      S_EMIT = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]  order_ff;
   logic [30:0] tol_ff;
   logic [15:0] lim_cfg_ff;

   logic [NW-1:0] n_ff, n_in, used_n;
   logic [15:0]   lim_ff, lim_in, cnt_ff, cnt_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, xa;
   logic          mode_ff, mode_in, bad_ff, bad_in, ok_ff, ok_in, conv_ff, conv_in;
   logic signed [31:0] acc_ff, acc_in, diag_ff, diag_in, xr_ff, mem_q_ff;
   logic [MAX_ORDER-1:0] xv_ff, xv_in;

   logic signed [31:0] x_ff [MAX_ORDER];
   logic signed [31:0] rhs_ff [MAX_ORDER];
   logic signed [31:0] matrix_mem [MAX_ORDER * MAX_ORDER];

   logic               rsp_v_ff, rsp_v_in, rsp_last_ff, rsp_last_in, rsp_conv_ff, rsp_conv_in;
   logic [2:0]         rsp_idx_ff, rsp_idx_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;

   logic        req_hs;
   logic [1:0]  func;
   logic [2:0]  row, col;
   logic signed [31:0] value;
   logic [AW-1:0] wa, ra;
   logic        mat_we, x_we, div_go, div_done;
   logic signed [31:0] x_rd, p_q, acc_op, acc_nx, r_val, div_quo;
   logic signed [63:0] prod;
   logic [31:0] r_mag;
   logic        j_last, i_last, k_last, term_on;

   assign req_tready = (state_ff == S_IDLE);
   assign req_hs     = req_tvalid && req_tready;
   assign func       = req_tuser;
   assign row        = req_tdata[2:0];
   assign col        = req_tdata[5:3];
   assign value      = req_tdata[37:6];
   assign csr_ready  = 1'b1;

   assign wa     = AW'(int'(row) * MAX_ORDER + int'(col));
   assign ra     = AW'(int'(i_ff) * MAX_ORDER + int'(j_ff));
   assign mat_we = req_hs && (func == gs_pkg::FUNC_MATRIX) &&
                   (int'(row) < MAX_ORDER) && (int'(col) < MAX_ORDER);

   assign xa   = (state_ff == S_EMIT) ? k_ff : j_ff;
   assign x_rd = xv_ff[xa] ? x_ff[xa] : 32'sd0;

   assign j_last = (NW'(j_ff) + NW'(1) == n_ff);
   assign i_last = (NW'(i_ff) + NW'(1) == n_ff);
   assign k_last = (NW'(k_ff) + NW'(1) == n_ff);

   assign term_on = mode_ff || (j_ff != i_ff);
   assign p_q     = gs_pkg::prod_to_q(prod);
   assign acc_op  = mode_ff ? gs_pkg::sat_add(acc_ff, p_q) : gs_pkg::sat_sub(acc_ff, p_q);
   assign acc_nx  = term_on ? acc_op : acc_ff;
   assign r_val   = gs_pkg::sat_sub(rhs_ff[i_ff], acc_ff);
   assign r_mag   = r_val[31] ? (~r_val + 32'd1) : r_val;

   gs_mul u_mul (
      .clock (clock),
      .a     (mem_q_ff),
      .b     (xr_ff),
      .prod  (prod)
   );

   gs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (acc_nx),
      .den   (diag_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      if (order_ff == 4'd0) begin
         used_n = NW'(1);
      end else if (int'(order_ff) > MAX_ORDER) begin
         used_n = NW'(MAX_ORDER);
      end else begin
         used_n = NW'(order_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      lim_in      = lim_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      mode_in     = mode_ff;
      bad_in      = bad_ff;
      ok_in       = ok_ff;
      conv_in     = conv_ff;
      acc_in      = acc_ff;
      diag_in     = diag_ff;
      xv_in       = xv_ff;
      rsp_v_in    = rsp_v_ff;
      rsp_idx_in  = rsp_idx_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_last_in = rsp_last_ff;
      rsp_conv_in = rsp_conv_ff;
      div_go      = 1'b0;
      x_we        = 1'b0;
      if (rsp_v_ff && rsp_tready) begin
         rsp_v_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_hs && func == gs_pkg::FUNC_START) begin
               n_in     = used_n;
               lim_in   = (lim_cfg_ff == 16'd0) ? 16'd1 : lim_cfg_ff;
               cnt_in   = '0;
               xv_in    = '0;
               i_in     = '0;
               j_in     = '0;
               mode_in  = 1'b0;
               bad_in   = 1'b0;
               acc_in   = rhs_ff[0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (!mode_ff && j_ff == i_ff) begin
               diag_in = mem_q_ff;
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_nx;
            if (!j_last) begin
               j_in     = j_ff + IW'(1);
               state_in = S_READ;
            end else if (mode_ff) begin
               state_in = S_RES;
            end else if (diag_ff == 32'sd0) begin
               bad_in   = 1'b1;
               conv_in  = 1'b0;
               k_in     = '0;
               state_in = S_EMIT;
            end else begin
               div_go   = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               x_we         = 1'b1;
               xv_in[i_ff]  = 1'b1;
               j_in         = '0;
               if (!i_last) begin
                  i_in     = i_ff + IW'(1);
                  acc_in   = rhs_ff[i_ff + IW'(1)];
               end else begin
                  cnt_in   = cnt_ff + 16'd1;
                  mode_in  = 1'b1;
                  i_in     = '0;
                  acc_in   = '0;
                  ok_in    = 1'b1;
               end
               state_in = S_READ;
            end
         end
         S_RES: begin
            if (r_mag >= {1'b0, tol_ff}) begin
               ok_in = 1'b0;
            end
            j_in   = '0;
            acc_in = '0;
            if (!i_last) begin
               i_in     = i_ff + IW'(1);
               state_in = S_READ;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (ok_ff || cnt_ff >= lim_ff) begin
               conv_in  = ok_ff;
               k_in     = '0;
               state_in = S_EMIT;
            end else begin
               mode_in  = 1'b0;
               i_in     = '0;
               j_in     = '0;
               acc_in   = rhs_ff[0];
               state_in = S_READ;
            end
         end
         S_EMIT: begin
            if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in    = 1'b1;
               rsp_idx_in  = 3'(k_ff);
               rsp_val_in  = bad_ff ? 32'sd0 : x_rd;
               rsp_last_in = k_last;
               rsp_conv_in = conv_ff;
               k_in        = k_ff + IW'(1);
               if (k_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         order_ff   <= gs_pkg::RESET_ORDER;
         tol_ff     <= gs_pkg::RESET_TOLERANCE;
         lim_cfg_ff <= gs_pkg::RESET_LIMIT;
         n_ff       <= NW'(MAX_ORDER);
         lim_ff     <= 16'd1;
         cnt_ff     <= '0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         mode_ff    <= 1'b0;
         bad_ff     <= 1'b0;
         ok_ff      <= 1'b0;
         conv_ff    <= 1'b0;
         xv_ff      <= '0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gs_pkg::CSR_ORDER:     order_ff   <= csr_data[3:0];
               gs_pkg::CSR_TOLERANCE: tol_ff     <= csr_data[30:0];
               gs_pkg::CSR_LIMIT:     lim_cfg_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         n_ff     <= n_in;
         lim_ff   <= lim_in;
         cnt_ff   <= cnt_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         mode_ff  <= mode_in;
         bad_ff   <= bad_in;
         ok_ff    <= ok_in;
         conv_ff  <= conv_in;
         xv_ff    <= xv_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      diag_ff     <= diag_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
      rsp_conv_ff <= rsp_conv_in;
      if (state_ff == S_READ) begin
         xr_ff <= x_rd;
      end
      if (x_we) begin
         x_ff[i_ff] <= div_quo;
      end
      if (req_hs && func == gs_pkg::FUNC_RHS && int'(row) < MAX_ORDER) begin
         rhs_ff[IW'(row)] <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (mat_we) begin
         matrix_mem[wa] <= value;
      end
      if (state_ff == S_READ) begin
         mem_q_ff <= matrix_mem[ra];
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {5'd0, rsp_val_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_conv_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV) else $error("divider done outside divide state");

   a_bad_first_sweep: assert property (@(posedge clock) disable iff (reset)
      (bad_ff && state_ff == S_EMIT) |-> cnt_ff == 16'd0)
      else $error("zero diagonal seen after a completed sweep");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && rsp_last_ff) |-> NW'(rsp_idx_ff) + NW'(1) == n_ff)
      else $error("last flag on wrong component");

   a_div_go_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_go |=> state_ff == S_DIV && diag_ff != 32'sd0)
      else $error("divide started on zero diagonal");
`endif

endmodule

// ===== rtl/gs_mul.sv =====
module gs_mul (
   input  logic               clock,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic signed [63:0] prod
);

   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/gs_div.sv =====
module gs_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quo
);

   localparam int DW = gs_pkg::DIV_W;
   localparam int SW = $clog2(DW);

   logic          busy_ff, fin_ff, done_ff, neg_ff;
   logic [SW-1:0] step_ff;
   logic [31:0]   den_ff, rem_ff;
   logic [DW-1:0] sh_ff;
   logic signed [31:0] quo_ff;

   logic [32:0] trial, diff;
   logic        ge;
   logic [31:0] un, ud;
   logic signed [31:0] sat_q;

   assign trial = {rem_ff, sh_ff[DW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});
   assign un    = num[31] ? (~num + 32'd1) : num;
   assign ud    = den[31] ? (~den + 32'd1) : den;

   always_comb begin
      if (!neg_ff) begin
         sat_q = (|sh_ff[DW-1:31]) ? gs_pkg::Q_MAX : sh_ff[31:0];
      end else if ((|sh_ff[DW-1:32]) || (sh_ff[31] && (|sh_ff[30:0]))) begin
         sat_q = gs_pkg::Q_MIN;
      end else begin
         sat_q = ~sh_ff[31:0] + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == SW'(DW - 1)) begin
            busy_ff <= 1'b0;
            fin_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= num[31] ^ den[31];
         den_ff  <= ud;
         rem_ff  <= '0;
         sh_ff   <= {un, {gs_pkg::Q_FRAC{1'b0}}};
         step_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[31:0] : trial[31:0];
         sh_ff   <= {sh_ff[DW-2:0], ge};
         step_ff <= step_ff + SW'(1);
      end
      if (fin_ff) begin
         quo_ff <= sat_q;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
